>>> hw/rtl/mf5_pkg.sv
`default_nettype none
package mf5_pkg;

   localparam int unsigned NET_PAIRS   = 99;
   localparam int unsigned STAGE_PAIRS = 9;
   localparam int unsigned NET_STAGES  = NET_PAIRS / STAGE_PAIRS;
   localparam int unsigned WIN_SIZE    = 25;
   localparam int unsigned MEDIAN_POS  = 12;

   localparam int unsigned FIFO_DEPTH  = 16;
   localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

   // configuration register indexes
   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_CHANNELS = 2'd2;

   // column tap source: a line store slot, or the item's own sample
   localparam logic [2:0] SEL_SLOT0 = 3'd0;
   localparam logic [2:0] SEL_OWN   = 3'd4;

   localparam logic [4:0] PAIRS [NET_PAIRS][2] = '{
      '{0,1},'{3,4},'{2,4},'{2,3},'{6,7},'{5,7},'{5,6},'{9,10},'{8,10},
      '{8,9},'{12,13},'{11,13},'{11,12},'{15,16},'{14,16},'{14,15},'{18,19},'{17,19},
      '{17,18},'{21,22},'{20,22},'{20,21},'{23,24},'{2,5},'{3,6},'{0,6},'{0,3},
      '{4,7},'{1,7},'{1,4},'{11,14},'{8,14},'{8,11},'{12,15},'{9,15},'{9,12},
      '{13,16},'{10,16},'{10,13},'{20,23},'{17,23},'{17,20},'{21,24},'{18,24},'{18,21},
      '{19,22},'{8,17},'{9,18},'{0,18},'{0,9},'{10,19},'{1,19},'{1,10},'{11,20},
      '{2,20},'{2,11},'{12,21},'{3,21},'{3,12},'{13,22},'{4,22},'{4,13},'{14,23},
      '{5,23},'{5,14},'{15,24},'{6,24},'{6,15},'{7,16},'{7,19},'{13,21},'{15,23},
      '{7,13},'{7,15},'{1,9},'{3,11},'{5,17},'{11,17},'{9,17},'{4,10},'{6,12},
      '{7,14},'{4,6},'{4,7},'{12,14},'{10,14},'{6,7},'{10,12},'{6,10},'{6,17},
      '{12,17},'{7,17},'{7,10},'{12,18},'{7,12},'{10,18},'{12,20},'{10,20},'{10,12}
   };

   typedef logic [WIN_SIZE-1:0][7:0] win_type;

   typedef struct packed {
      logic [1:0]      chan_idx;
      logic [2:0]      chans;
      logic            first_col;
      logic            emit;
      logic            row_end;
      logic            eof;
      logic            w_ge2;
      logic [7:0]      smp;
      logic [4:0][2:0] sel;
   } item_type;

   typedef struct packed {
      win_type vals;
      logic    last;
      logic    eof;
   } snap_type;

   typedef struct packed {
      logic [7:0] median;
      logic       last;
      logic       eof;
   } res_type;

   // one group of compare-exchange pairs of the sorting network
   function automatic win_type cx_stage(win_type a, int unsigned st);
      win_type     r;
      logic [7:0]  p;
      logic [7:0]  q;
      int unsigned idx;
      r = a;
      for (int unsigned n = 0; n < STAGE_PAIRS; n++) begin
         idx = st * STAGE_PAIRS + n;
         p = r[PAIRS[idx][0]];
         q = r[PAIRS[idx][1]];
         if (p > q) begin
            r[PAIRS[idx][0]] = q;
            r[PAIRS[idx][1]] = p;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/median_filter_5x5_core.sv
// 5x5 median filter, one 8-bit sample per item, 1 to 4 interleaved channels.
// Throughput: one item per cycle while the output buffer has room; a row-end item
// holds the input while the row flushes, each channel in turn.
// An item's first result passes the window update, the 11 stages of the sorting
// network and the output buffer write, in that order.
// Reset: synchronous; registers return to 640 x 480, 1 channel; line store is not cleared.
`default_nettype none
module median_filter_5x5_core #(
   parameter int unsigned MAX_ROW_SAMPLES = 4096,
   parameter int unsigned MAX_CHANNELS    = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_sample,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_median,
   output      logic        rsp_last_in_run,
   output      logic        rsp_end_of_frame,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned IW  = $clog2(MAX_ROW_SAMPLES);
   localparam int unsigned SCW = $clog2(MAX_ROW_SAMPLES + 1);
   localparam int unsigned XW  = (SCW > 11) ? SCW : 11;
   localparam int unsigned RECIP3 = 21846;  // ceil(2^16 / 3)
   localparam logic [XW-1:0] CAP1 = XW'(MAX_ROW_SAMPLES / 1);
   localparam logic [XW-1:0] CAP2 = XW'(MAX_ROW_SAMPLES / 2);
   localparam logic [XW-1:0] CAP3 = XW'(MAX_ROW_SAMPLES / 3);
   localparam logic [XW-1:0] CAP4 = XW'(MAX_ROW_SAMPLES / 4);

   logic [10:0]    width_ff;
   logic [15:0]    height_ff;
   logic [2:0]     chan_ff;
   logic [15:0]    row_ff, row_in;
   logic [SCW-1:0] samp_ff, samp_in;

   logic [2:0]      ch_eff;
   logic [XW-1:0]   cap, w_x, w_eff;
   logic [10:0]     w0;
   logic [SCW+2:0]  s_prod;
   logic [SCW-1:0]  s_eff, s_m1;
   logic [15:0]     h_eff;
   logic [16:0]     h_p2, hm1;
   logic            wrap;
   logic [15:0]     k;
   logic [SCW-1:0]  i_pre, i;
   logic            drain_row, ignore, acc;
   logic [SCW+14:0] prod3;
   logic [SCW-1:0]  q3, c3w;
   logic [1:0]      c;
   logic            row_end;
   logic [16:0]     kd [5];
   logic [16:0]     r17 [5];
   logic [16:0]     rc [5];
   logic [4:0][2:0] tap_sel;

   mf5_pkg::item_type item;
   mf5_pkg::snap_type snap;
   mf5_pkg::res_type  med_res, out_res;
   logic              win_busy, win_done, snap_valid, room, med_valid;
   logic [31:0]       rd_data;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
         chan_ff   <= 3'd1;
      end else if (csr_valid) begin
         case (csr_index)
            mf5_pkg::REG_WIDTH:    width_ff  <= csr_data[10:0];
            mf5_pkg::REG_HEIGHT:   height_ff <= csr_data;
            mf5_pkg::REG_CHANNELS: chan_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // ---- effective geometry ----
   always_comb begin
      if (chan_ff == 3'd0) begin
         ch_eff = 3'd1;
      end else if (chan_ff > 3'(MAX_CHANNELS)) begin
         ch_eff = 3'(MAX_CHANNELS);
      end else begin
         ch_eff = chan_ff;
      end
      case (ch_eff)
         3'd1:    cap = CAP1;
         3'd2:    cap = CAP2;
         3'd3:    cap = CAP3;
         default: cap = CAP4;
      endcase
   end

   assign w0     = (width_ff == 11'd0) ? 11'd1 : width_ff;
   assign w_x    = XW'(w0);
   assign w_eff  = (w_x > cap) ? cap : w_x;
   assign s_prod = (SCW+3)'(w_eff[SCW-1:0]) * (SCW+3)'(ch_eff);
   assign s_eff  = s_prod[SCW-1:0];
   assign s_m1   = s_eff - SCW'(1);
   assign h_eff  = (height_ff == 16'd0) ? 16'd1 : height_ff;
   assign h_p2   = {1'b0, h_eff} + 17'd2;
   assign hm1    = {1'b0, h_eff} - 17'd1;

   // ---- position of this item ----
   assign wrap      = {1'b0, row_ff} >= h_p2;
   assign k         = wrap ? 16'd0 : row_ff;
   assign i_pre     = wrap ? '0 : samp_ff;
   assign i         = (i_pre >= s_eff) ? s_m1 : i_pre;
   assign drain_row = k >= h_eff;
   assign ignore    = req_mode && !drain_row;
   assign row_end   = i == s_m1;

   // channel index: i mod channels, divide by three through a reciprocal
   assign prod3 = (SCW+15)'(i) * (SCW+15)'(RECIP3);
   assign q3    = SCW'(prod3[SCW+14:16]);
   assign c3w   = i - q3 - q3 - q3;

   always_comb begin
      case (ch_eff)
         3'd1:    c = 2'd0;
         3'd2:    c = {1'b0, i[0]};
         3'd3:    c = c3w[1:0];
         default: c = i[1:0];
      endcase
   end

   // rows k-4..k clamped to the image, mapped to a line slot or the own sample
   always_comb begin
      for (int d = 0; d < 5; d++) begin
         kd[d]  = {1'b0, k} + 17'(d);
         r17[d] = (kd[d] < 17'd4) ? 17'd0 : kd[d] - 17'd4;
         rc[d]  = (r17[d] > hm1) ? hm1 : r17[d];
         if (rc[d] == {1'b0, k}) begin
            tap_sel[d] = mf5_pkg::SEL_OWN;
         end else begin
            tap_sel[d] = mf5_pkg::SEL_SLOT0 | {1'b0, rc[d][1:0]};
         end
      end
   end

   assign item.sel       = tap_sel;
   assign item.chan_idx  = c;
   assign item.chans     = ch_eff;
   assign item.first_col = i < SCW'(ch_eff);
   assign item.emit      = i >= SCW'({ch_eff, 1'b0});
   assign item.row_end   = row_end;
   assign item.eof       = row_end && ({1'b0, k} == {1'b0, h_eff} + 17'd1);
   assign item.w_ge2     = w_eff >= XW'(2);
   assign item.smp       = req_sample;

   // ---- handshake and counters ----
   assign req_stall = win_busy && !win_done;
   assign acc       = req_valid && !req_stall;

   always_comb begin
      row_in  = row_ff;
      samp_in = samp_ff;
      if (acc) begin
         if (ignore) begin
            row_in  = k;
            samp_in = i;
         end else if (row_end) begin
            samp_in = '0;
            row_in  = ({1'b0, k} + 17'd1 >= h_p2) ? 16'd0 : k + 16'd1;
         end else begin
            samp_in = i + SCW'(1);
            row_in  = k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         samp_ff <= '0;
      end else begin
         row_ff  <= row_in;
         samp_ff <= samp_in;
      end
   end

   mf5_line_store #(
      .DEPTH(MAX_ROW_SAMPLES),
      .AW   (IW)
   ) u_line_store (
      .clock  (clock),
      .rd_en  (acc),
      .wr_en  (acc && !drain_row && !req_mode),
      .addr   (i[IW-1:0]),
      .wr_slot(k[1:0]),
      .wr_data(req_sample),
      .rd_data(rd_data)
   );

   mf5_window #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .load      (acc && !ignore && (k >= 16'd2)),
      .load_item (item),
      .rd_data   (rd_data),
      .room      (room),
      .busy      (win_busy),
      .done      (win_done),
      .snap_valid(snap_valid),
      .snap      (snap)
   );

   mf5_median u_median (
      .clock    (clock),
      .reset    (reset),
      .in_valid (snap_valid),
      .in_snap  (snap),
      .out_valid(med_valid),
      .out_res  (med_res)
   );

   mf5_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .reserve  (snap_valid),
      .room     (room),
      .push     (med_valid),
      .push_res (med_res),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_res  (out_res)
   );

   assign rsp_median       = out_res.median;
   assign rsp_last_in_run  = out_res.last;
   assign rsp_end_of_frame = out_res.eof;

   // ---- checks ----
   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> win_busy)
      else $error("input stalled with the window stage empty");

   a_issue_needs_credit: assert property (@(posedge clock) disable iff (reset)
      snap_valid |-> room)
      else $error("median issued without output credit");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_last_in_run)
      else $error("end of frame on a result that is not last of its item");

endmodule
`default_nettype wire

>>> hw/rtl/mf5_line_store.sv
`default_nettype none
module mf5_line_store #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [1:0]    wr_slot,
   input  wire logic [7:0]    wr_data,
   output      logic [31:0]   rd_data
);

   // one word per row position, one byte per line slot
   logic [31:0] mem [DEPTH];
   logic [31:0] rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr][{wr_slot, 3'b000} +: 8] <= wr_data;
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mf5_window.sv
`default_nettype none
module mf5_window #(
   parameter int unsigned MAX_CHANNELS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire mf5_pkg::item_type load_item,
   input  wire logic [31:0]       rd_data,
   input  wire logic              room,
   output      logic              busy,
   output      logic              done,
   output      logic              snap_valid,
   output      mf5_pkg::snap_type snap
);

   localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [39:0]       win_ff [MAX_CHANNELS][5];
   logic [39:0]       win_in [MAX_CHANNELS][5];
   mf5_pkg::item_type item_ff;
   logic              busy_ff, busy_in;
   logic              flush_ff, flush_in;
   logic              pass_ff, pass_in;
   logic [1:0]        fch_ff, fch_in;

   logic [39:0] col;
   logic [39:0] cur [5];
   logic [39:0] nxt [5];
   logic [1:0]  sel_ch;
   logic [2:0]  chans_m1;
   logic        last_f;
   logic        emit;
   logic        go;
   logic        shift_f;

   always_comb begin
      for (int d = 0; d < 5; d++) begin
         if (item_ff.sel[d] == mf5_pkg::SEL_OWN) begin
            col[d*8 +: 8] = item_ff.smp;
         end else begin
            col[d*8 +: 8] = rd_data[{item_ff.sel[d][1:0], 3'b000} +: 8];
         end
      end
   end

   assign sel_ch   = flush_ff ? fch_ff : item_ff.chan_idx;
   assign chans_m1 = item_ff.chans - 3'd1;
   assign last_f   = (pass_ff == item_ff.w_ge2) && ({1'b0, fch_ff} == chans_m1);
   assign emit     = flush_ff | item_ff.emit;
   assign go       = busy_ff && (!emit || room);
   assign shift_f  = item_ff.w_ge2 | pass_ff;

   always_comb begin
      for (int j = 0; j < 5; j++) begin
         cur[j] = win_ff[sel_ch[CHW-1:0]][j];
      end
      for (int j = 0; j < 4; j++) begin
         if (flush_ff) begin
            nxt[j] = shift_f ? cur[j+1] : cur[j];
         end else begin
            nxt[j] = item_ff.first_col ? col : cur[j+1];
         end
      end
      if (flush_ff) begin
         nxt[4] = cur[4];
      end else begin
         nxt[4] = col;
      end
   end

   always_comb begin
      for (int cc = 0; cc < MAX_CHANNELS; cc++) begin
         for (int j = 0; j < 5; j++) begin
            win_in[cc][j] = win_ff[cc][j];
         end
      end
      if (go) begin
         for (int j = 0; j < 5; j++) begin
            win_in[sel_ch[CHW-1:0]][j] = nxt[j];
         end
      end
   end

   assign done = go && (flush_ff ? last_f : !item_ff.row_end);

   always_comb begin
      busy_in  = busy_ff;
      flush_in = flush_ff;
      pass_in  = pass_ff;
      fch_in   = fch_ff;
      if (go) begin
         if (!flush_ff) begin
            if (item_ff.row_end) begin
               flush_in = 1'b1;
               pass_in  = 1'b0;
               fch_in   = 2'd0;
            end
         end else if (last_f) begin
            flush_in = 1'b0;
         end else if ({1'b0, fch_ff} == chans_m1) begin
            fch_in  = 2'd0;
            pass_in = 1'b1;
         end else begin
            fch_in = fch_ff + 2'd1;
         end
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         flush_ff <= 1'b0;
         pass_ff  <= 1'b0;
         fch_ff   <= 2'd0;
         for (int cc = 0; cc < MAX_CHANNELS; cc++) begin
            for (int j = 0; j < 5; j++) begin
               win_ff[cc][j] <= '0;
            end
         end
      end else begin
         busy_ff  <= busy_in;
         flush_ff <= flush_in;
         pass_ff  <= pass_in;
         fch_ff   <= fch_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   always_comb begin
      for (int d = 0; d < 5; d++) begin
         for (int j = 0; j < 5; j++) begin
            snap.vals[d*5 + j] = nxt[j][d*8 +: 8];
         end
      end
      snap.last = flush_ff ? last_f : !item_ff.row_end;
      snap.eof  = flush_ff && last_f && item_ff.eof;
   end

   assign snap_valid = go && emit;
   assign busy       = busy_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mf5_median.sv
`default_nettype none
module mf5_median (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire mf5_pkg::snap_type in_snap,
   output      logic              out_valid,
   output      mf5_pkg::res_type  out_res
);

   localparam int unsigned NS = mf5_pkg::NET_STAGES;

   logic             v_ff [NS+1];
   mf5_pkg::win_type a_ff [NS+1];
   logic             l_ff [NS+1];
   logic             e_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      a_ff[0] <= in_snap.vals;
      l_ff[0] <= in_snap.last;
      e_ff[0] <= in_snap.eof;
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else begin
            v_ff[g+1] <= v_ff[g];
         end
         a_ff[g+1] <= mf5_pkg::cx_stage(a_ff[g], g);
         l_ff[g+1] <= l_ff[g];
         e_ff[g+1] <= e_ff[g];
      end
   end

   assign out_valid      = v_ff[NS];
   assign out_res.median = a_ff[NS][mf5_pkg::MEDIAN_POS];
   assign out_res.last   = l_ff[NS];
   assign out_res.eof    = e_ff[NS];

endmodule
`default_nettype wire

>>> hw/rtl/mf5_out_fifo.sv
`default_nettype none
module mf5_out_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             reserve,
   output      logic             room,
   input  wire logic             push,
   input  wire mf5_pkg::res_type push_res,
   output      logic             out_valid,
   input  wire logic             out_stall,
   output      mf5_pkg::res_type out_res
);

   localparam int unsigned AW = mf5_pkg::FIFO_AW;

   mf5_pkg::res_type mem_ff [mf5_pkg::FIFO_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      cnt_ff, cnt_in;
   logic [AW:0]      credit_ff, credit_in;
   logic             pop;

   assign out_valid = cnt_ff != '0;
   assign pop       = out_valid && !out_stall;
   assign out_res   = mem_ff[rd_ptr_ff];
   // credits count items issued into the median pipe and not yet taken
   assign room      = credit_ff != (AW+1)'(mf5_pkg::FIFO_DEPTH);

   assign cnt_in    = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   assign credit_in = credit_ff + (AW+1)'(reserve) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         credit_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_res;
      end
   end

endmodule
`default_nettype wire

>>> test/tb_median_filter_5x5_core.sv
`timescale 1ns / 1ps

module tb_median_filter_5x5_core;

   localparam int unsigned ROW_MAX   = 4096;
   localparam int unsigned CHAN_MAX  = 4;
   localparam int unsigned IDLE_MAX  = 5000;
   localparam int unsigned TAIL_WAIT = 40;

   // Tracks what the filter should produce and checks its results in order.
   class median_sb;
      logic [10:0] width_reg;
      logic [15:0] height_reg;
      logic [2:0]  chan_reg;
      logic [7:0]  rows_mem [4*ROW_MAX];
      logic [39:0] cols [CHAN_MAX*5];
      int unsigned row_cnt;
      int unsigned smp_cnt;
      mf5_pkg::res_type medians_q [$];
      int          errors;
      int          results;
      int          taken;

      function new();
         width_reg  = 11'd640;
         height_reg = 16'd480;
         chan_reg   = 3'd1;
         foreach (cols[n]) cols[n] = '0;
         row_cnt = 0;
         smp_cnt = 0;
         errors  = 0;
         results = 0;
         taken   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            mf5_pkg::REG_WIDTH:    width_reg  = val[10:0];
            mf5_pkg::REG_HEIGHT:   height_reg = val;
            mf5_pkg::REG_CHANNELS: chan_reg   = val[2:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] win_median(int unsigned c);
         logic [7:0] vals [25];
         logic [7:0] t;
         int         m;
         for (int d = 0; d < 5; d++)
            for (int j = 0; j < 5; j++)
               vals[d*5+j] = cols[c*5+j][8*d +: 8];
         for (int n = 1; n < 25; n++) begin
            t = vals[n];
            m = n - 1;
            while (m >= 0 && vals[m] > t) begin
               vals[m+1] = vals[m];
               m--;
            end
            vals[m+1] = t;
         end
         return vals[12];
      endfunction

      function void shift_col(int unsigned c, logic [39:0] col);
         for (int j = 0; j < 4; j++) cols[c*5+j] = cols[c*5+j+1];
         cols[c*5+4] = col;
      endfunction

      function void note_input(logic mode, logic [7:0] smp);
         int unsigned ch, w, s, h, k, i, x, c, passes;
         int          r, o;
         bit          drain, row_end;
         logic [39:0] col;
         logic [7:0]  v;
         mf5_pkg::res_type outs [$];
         mf5_pkg::res_type e;
         ch = (chan_reg == 0) ? 1 : chan_reg;
         if (ch > CHAN_MAX) ch = CHAN_MAX;
         w = (width_reg == 0) ? 1 : width_reg;
         if (w > ROW_MAX / ch) w = ROW_MAX / ch;
         s = w * ch;
         h = (height_reg == 0) ? 1 : height_reg;
         if (row_cnt >= h + 2) begin
            row_cnt = 0;
            smp_cnt = 0;
         end
         if (smp_cnt >= s) smp_cnt = s - 1;
         k = row_cnt;
         i = smp_cnt;
         drain = (k >= h);
         // drain tick inside the image is dropped
         if (mode && !drain) return;
         taken++;
         x = i / ch;
         c = i % ch;
         row_end = (i == s - 1);
         col = '0;
         for (int d = 0; d < 5; d++) begin
            r = int'(k) - 4 + d;
            if (r < 0) r = 0;
            if (r > int'(h) - 1) r = int'(h) - 1;
            if (r == int'(k)) v = smp;
            else v = rows_mem[(r % 4) * ROW_MAX + i];
            col[8*d +: 8] = v;
         end
         if (!drain) rows_mem[(k % 4) * ROW_MAX + i] = smp;
         o = int'(k) - 2;
         e.last = 1'b0;
         e.eof  = 1'b0;
         if (o >= 0) begin
            if (x == 0) begin
               for (int d = 0; d < 5; d++) cols[c*5+d] = col;
            end else begin
               shift_col(c, col);
            end
            if (x >= 2) begin
               e.median = win_median(c);
               outs.push_back(e);
            end
            if (row_end) begin
               passes = (w >= 2) ? 2 : 1;
               for (int p = 0; p < passes; p++)
                  for (int cc = 0; cc < ch; cc++) begin
                     if (w >= 2 || p > 0) shift_col(cc, cols[cc*5+4]);
                     e.median = win_median(cc);
                     outs.push_back(e);
                  end
            end
         end
         if (outs.size() > 0) begin
            outs[outs.size()-1].last = 1'b1;
            if (row_end && o == int'(h) - 1) outs[outs.size()-1].eof = 1'b1;
         end
         foreach (outs[n]) medians_q.push_back(outs[n]);
         smp_cnt = i + 1;
         if (smp_cnt >= s) begin
            smp_cnt = 0;
            row_cnt = k + 1;
            if (row_cnt >= h + 2) row_cnt = 0;
         end
      endfunction

      function void check_result(logic [7:0] med, logic last, logic eof);
         mf5_pkg::res_type e;
         results++;
         if (medians_q.size() == 0) begin
            $error("unexpected result: median %0d last_in_run %0b end_of_frame %0b",
                   med, last, eof);
            errors++;
            return;
         end
         e = medians_q.pop_front();
         if (med !== e.median) begin
            $error("median: expected %0d, got %0d", e.median, med);
            errors++;
         end
         if (last !== e.last) begin
            $error("last_in_run: expected %0b, got %0b", e.last, last);
            errors++;
         end
         if (eof !== e.eof) begin
            $error("end_of_frame: expected %0b, got %0b", e.eof, eof);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [7:0]  req_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_median;
   logic        rsp_last_in_run;
   logic        rsp_end_of_frame;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   median_sb    sb;
   int unsigned burst_left;
   int unsigned frames_run;
   int unsigned rand_items;
   int unsigned idle_cycles;
   bit          hold_req;

   median_filter_5x5_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median       (rsp_median),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_mode, req_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_median, rsp_last_in_run, rsp_end_of_frame);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX) begin
            $display("timeout: no item moved for %0d cycles", IDLE_MAX);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver stall patterns, with a long hold-off whenever hold_req is set
   initial begin
      int unsigned pat;
      rsp_stall = 1'b0;
      forever begin
         if (hold_req) begin
            repeat (400) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_req = 1'b0;
         end else begin
            pat = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
               @(negedge clock);
               if (hold_req) break;
               case (pat)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 99) < 30);
                  2: rsp_stall <= ~rsp_stall;
                  default: rsp_stall <= ($urandom_range(0, 99) < 80);
               endcase
            end
         end
      end
   end

   task automatic send_item(logic mode, logic [7:0] smp);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (sb.medians_q.size() > 0) @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_sample(int unsigned vmode);
      case (vmode)
         1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         2: return 8'(120 + $urandom_range(0, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one whole frame: image rows, then two rows of drain ticks
   task automatic run_frame(logic [15:0] w_raw, logic [15:0] h_raw, logic [15:0] ch_raw,
                            int unsigned noise_pct, int unsigned vmode, bit counted);
      int unsigned ch, w, s, h;
      write_csr(mf5_pkg::REG_WIDTH, w_raw);
      write_csr(mf5_pkg::REG_HEIGHT, h_raw);
      write_csr(mf5_pkg::REG_CHANNELS, ch_raw);
      ch = (ch_raw[2:0] == 0) ? 1 : ch_raw[2:0];
      if (ch > CHAN_MAX) ch = CHAN_MAX;
      w = (w_raw[10:0] == 0) ? 1 : w_raw[10:0];
      if (w > ROW_MAX / ch) w = ROW_MAX / ch;
      s = w * ch;
      h = (h_raw == 0) ? 1 : h_raw;
      for (int unsigned k = 0; k < h + 2; k++)
         for (int unsigned i = 0; i < s; i++) begin
            if (k < h) begin
               if ($urandom_range(0, 99) < noise_pct)
                  send_item(1'b1, 8'($urandom_range(0, 255)));
               send_item(1'b0, pick_sample(vmode));
            end else if ($urandom_range(0, 99) < noise_pct) begin
               send_item(1'b0, 8'($urandom_range(0, 255)));
            end else begin
               send_item(1'b1, 8'($urandom_range(0, 255)));
            end
            if (counted) rand_items++;
         end
      frames_run++;
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = 1'b0;
      req_sample = 8'd0;
      csr_valid  = 1'b0;
      csr_index  = mf5_pkg::REG_WIDTH;
      csr_data   = 16'd0;
      burst_left = 0;
      frames_run = 0;
      rand_items = 0;
      hold_req   = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: edge values, narrow rows, odd register values
      run_frame(16'd5, 16'd3, 16'd1, 10, 1, 0);
      run_frame(16'd1, 16'd1, 16'd1, 20, 0, 0);
      run_frame(16'd2, 16'd2, 16'd0, 20, 0, 0);
      run_frame(16'd3, 16'd2, 16'd7, 0, 1, 0);
      run_frame(16'd0, 16'd0, 16'd4, 30, 0, 0);
      run_frame(16'd1, 16'd4, 16'd5, 0, 2, 0);

      // input backs up while results are held off
      hold_req = 1'b1;
      run_frame(16'd6, 16'd6, 16'd2, 5, 0, 1);

      while (rand_items < 330)
         run_frame(16'($urandom_range(1, 10)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 7)), $urandom_range(0, 1) * 8,
                   $urandom_range(0, 2), 1);

      req_valid <= 1'b0;
      while (sb.medians_q.size() > 0) @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);
      $display("%0d frames, %0d items taken, %0d medians checked (%0d random-phase items)",
               frames_run, sb.taken, sb.results, rand_items);
      $display("covered 1..4 channels, one-pixel to ten-pixel rows, heights 1..6, drain noise");
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
